/* hw/rtl/sem_pkg.sv */
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the RGB Sobel edge magnitude core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sem_pkg;

   // Widest column counter over the whole parameter range.
   localparam int COL_MAX_W = 13;
   // Width used for size compares (12-bit registers, counters up to 13 bits).
   localparam int CMP_W     = 14;
   // Register indexes of the configuration port.
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   // Digit steps of the square root (22-bit radicand, two bits a step).
   localparam int ROOT_STEPS = 11;
   localparam logic [3:0] ROOT_LAST = 4'(ROOT_STEPS - 1);

   // One classified item, passed from the front end to the back end.
   typedef struct packed {
      logic [7:0]           red;
      logic [7:0]           green;
      logic [7:0]           blue;
      logic [COL_MAX_W-1:0] col;
      logic                 emit;
      logic                 top;
      logic                 bottom;
      logic                 left;
      logic                 right;
      logic                 last;
   } item_type;

   // Queue status passed from the queue to the front end and the back end.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_GRAD,
      S_SQUARE,
      S_ROOT,
      S_OUT
   } back_state_type;

endpackage

`default_nettype wire

/* hw/rtl/sem_fifo.sv */
// ----------------------------------------------------------------------------
// sem_fifo
// Two-entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sem_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire sem_pkg::item_type         push_item,
   input  wire logic                      pop,
   output sem_pkg::item_type              pop_item,
   output sem_pkg::queue_status_type      status
);
   import sem_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full)) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty)) else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/sem_front.sv */
// ----------------------------------------------------------------------------
// sem_front
// Accepts pixel beats, tracks stream and result positions, classifies items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sem_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [23:0]           req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [11:0]           csr_wdata,
   input  wire sem_pkg::queue_status_type status,
   output logic                       push,
   output sem_pkg::item_type          push_item
);
   import sem_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
   localparam logic [CMP_W-1:0] MAX_H_C = CMP_W'(MAX_HEIGHT);

   logic [11:0]      width_ff, width_in;
   logic [11:0]      height_ff, height_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [11:0]      in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   logic [CMP_W-1:0] w_eff, h_eff;
   logic [CMP_W-1:0] in_col_next, out_col_next, out_row_next;
   logic             emit, last, restart, accept;

   assign req_tready = !status.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept;

   // Sizes clamped to 1..maximum.
   always_comb begin
      if (width_ff == 12'd0) begin
         w_eff = CMP_W'(1);
      end else if (CMP_W'(width_ff) > MAX_W_C) begin
         w_eff = MAX_W_C;
      end else begin
         w_eff = CMP_W'(width_ff);
      end
      if (height_ff == 12'd0) begin
         h_eff = CMP_W'(1);
      end else if (CMP_W'(height_ff) > MAX_H_C) begin
         h_eff = MAX_H_C;
      end else begin
         h_eff = CMP_W'(height_ff);
      end
   end

   // Classification of the current beat.
   always_comb begin
      in_col_next  = CMP_W'(in_col_ff) + CMP_W'(1);
      out_col_next = CMP_W'(out_col_ff) + CMP_W'(1);
      out_row_next = CMP_W'(out_row_ff) + CMP_W'(1);
      emit = (in_row_ff >= 12'd2) || ((in_row_ff == 12'd1) && (in_col_ff != '0));
      last = emit && (out_row_next >= h_eff) && (out_col_next >= w_eff);

      push_item.red    = req_tuser ? 8'd0 : req_tdata[7:0];
      push_item.green  = req_tuser ? 8'd0 : req_tdata[15:8];
      push_item.blue   = req_tuser ? 8'd0 : req_tdata[23:16];
      push_item.col    = COL_MAX_W'(in_col_ff);
      push_item.emit   = emit;
      push_item.top    = (out_row_ff == '0);
      push_item.bottom = (out_row_next >= h_eff);
      push_item.left   = (out_col_ff == '0);
      push_item.right  = (out_col_next >= w_eff);
      push_item.last   = last;
   end

   // Register writes and position counters.
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      restart    = 1'b0;
      if (accept) begin
         if (in_col_next >= w_eff) begin
            in_col_in = '0;
            if (in_row_ff != 12'hFFF) begin
               in_row_in = in_row_ff + 12'd1;
            end
         end else begin
            in_col_in = in_col_next[COL_W-1:0];
         end
         if (emit) begin
            if (last) begin
               restart = 1'b1;
            end else if (out_col_next >= w_eff) begin
               out_col_in = '0;
               out_row_in = out_row_next[ROW_W-1:0];
            end else begin
               out_col_in = out_col_next[COL_W-1:0];
            end
         end
      end
      if (csr_we && csr_index == REG_IMAGE_WIDTH) begin
         width_in = csr_wdata;
         restart  = 1'b1;
      end
      if (csr_we && csr_index == REG_IMAGE_HEIGHT) begin
         height_in = csr_wdata;
         restart   = 1'b1;
      end
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 12'd640;
         height_ff  <= 12'd480;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(in_col_ff) < w_eff) else $error("input column past row end");
   a_out_col_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(out_col_ff) < w_eff) else $error("result column past row end");
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (out_col_ff == '0 && out_row_ff == '0 && in_row_ff == '0))
      else $error("frame end did not restart positions");
`endif

endmodule

`default_nettype wire

/* hw/rtl/sem_back.sv */
// ----------------------------------------------------------------------------
// sem_back
// Row stores, 3x3 window, Sobel gradients and a digit-serial rounded root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sem_back #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sem_pkg::queue_status_type status,
   input  wire sem_pkg::item_type         pop_item,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [23:0]                    rsp_tdata,
   output logic                           rsp_tlast
);
   import sem_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   back_state_type state_ff, state_in;

   logic [23:0] upper_mem [MAX_WIDTH];
   logic [23:0] middle_mem [MAX_WIDTH];
   logic [23:0] up_rd_ff, mid_rd_ff;

   item_type    item_ff;
   logic [7:0]  win_ff [9][3];
   logic [9:0]  ax_ff [3];
   logic [9:0]  ay_ff [3];
   logic [21:0] rad_ff [3];
   logic [13:0] rem_ff [3];
   logic [10:0] root_ff [3];
   logic [3:0]  step_ff;

   logic [23:0] px;
   logic        mem_we, load_out, out_free;
   logic [7:0]  m [9][3];
   logic [10:0] sum_a, sum_b, sum_c, sum_d, gx, gy;
   logic [9:0]  gx_abs [3];
   logic [9:0]  gy_abs [3];
   logic [13:0] rem_sh [3];
   logic [13:0] trial [3];
   logic [11:0] rounded [3];
   logic [7:0]  mag [3];

   assign px       = {item_ff.blue, item_ff.green, item_ff.red};
   assign out_free = !rsp_tvalid || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (!status.empty) state_in = S_UPDATE;
         S_UPDATE: state_in = item_ff.emit ? S_GRAD : S_IDLE;
         S_GRAD:   state_in = S_SQUARE;
         S_SQUARE: state_in = S_ROOT;
         S_ROOT:   if (step_ff == ROOT_LAST) state_in = S_OUT;
         S_OUT:    if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      pop      = 1'b0;
      mem_we   = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         S_IDLE:   pop = !status.empty;
         S_UPDATE: mem_we = 1'b1;
         S_OUT:    load_out = out_free;
         default:  pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Row stores: read when an item is taken, written back in the following cycle.
   always_ff @(posedge clock) begin
      if (pop) begin
         up_rd_ff  <= upper_mem[pop_item.col[COL_W-1:0]];
         mid_rd_ff <= middle_mem[pop_item.col[COL_W-1:0]];
      end
      if (mem_we) begin
         upper_mem[item_ff.col[COL_W-1:0]]  <= mid_rd_ff;
         middle_mem[item_ff.col[COL_W-1:0]] <= px;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= pop_item;
      end
   end

   // Window shift: columns move left, the new right column enters.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[i][c] <= 8'd0;
            end
         end
      end else if (mem_we) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r*3][c]   <= win_ff[r*3+1][c];
               win_ff[r*3+1][c] <= win_ff[r*3+2][c];
            end
            win_ff[2][c] <= up_rd_ff[c*8 +: 8];
            win_ff[5][c] <= mid_rd_ff[c*8 +: 8];
            win_ff[8][c] <= px[c*8 +: 8];
         end
      end
   end

   // Edge masking and gradients per channel.
   always_comb begin
      sum_a = '0;
      sum_b = '0;
      sum_c = '0;
      sum_d = '0;
      gx    = '0;
      gy    = '0;
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < 9; i++) begin
            m[i][c] = win_ff[i][c];
         end
         if (item_ff.top) begin
            m[0][c] = 8'd0; m[1][c] = 8'd0; m[2][c] = 8'd0;
         end
         if (item_ff.bottom) begin
            m[6][c] = 8'd0; m[7][c] = 8'd0; m[8][c] = 8'd0;
         end
         if (item_ff.left) begin
            m[0][c] = 8'd0; m[3][c] = 8'd0; m[6][c] = 8'd0;
         end
         if (item_ff.right) begin
            m[2][c] = 8'd0; m[5][c] = 8'd0; m[8][c] = 8'd0;
         end
         sum_a = 11'(m[2][c]) + {2'b0, m[5][c], 1'b0} + 11'(m[8][c]);
         sum_b = 11'(m[0][c]) + {2'b0, m[3][c], 1'b0} + 11'(m[6][c]);
         sum_c = 11'(m[6][c]) + {2'b0, m[7][c], 1'b0} + 11'(m[8][c]);
         sum_d = 11'(m[0][c]) + {2'b0, m[1][c], 1'b0} + 11'(m[2][c]);
         gx = sum_a - sum_b;
         gy = sum_c - sum_d;
         gx_abs[c] = gx[10] ? 10'(-gx) : gx[9:0];
         gy_abs[c] = gy[10] ? 10'(-gy) : gy[9:0];
      end
   end

   // One root digit per cycle for each channel.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rem_sh[c]  = {rem_ff[c][11:0], rad_ff[c][21:20]};
         trial[c]   = {1'b0, root_ff[c], 2'b01};
         rounded[c] = {1'b0, root_ff[c]} +
                      12'((rem_ff[c] > 14'(root_ff[c])) ? 1 : 0);
         mag[c]     = (rounded[c] > 12'd255) ? 8'd255 : rounded[c][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_GRAD) begin
         for (int c = 0; c < 3; c++) begin
            ax_ff[c] <= gx_abs[c];
            ay_ff[c] <= gy_abs[c];
         end
      end
      if (state_ff == S_SQUARE) begin
         for (int c = 0; c < 3; c++) begin
            rad_ff[c]  <= {12'd0, ax_ff[c]} * {12'd0, ax_ff[c]} +
                          {12'd0, ay_ff[c]} * {12'd0, ay_ff[c]};
            rem_ff[c]  <= '0;
            root_ff[c] <= '0;
         end
         step_ff <= 4'd0;
      end
      if (state_ff == S_ROOT) begin
         for (int c = 0; c < 3; c++) begin
            rad_ff[c] <= {rad_ff[c][19:0], 2'b00};
            if (rem_sh[c] >= trial[c]) begin
               rem_ff[c]  <= rem_sh[c] - trial[c];
               root_ff[c] <= {root_ff[c][9:0], 1'b1};
            end else begin
               rem_ff[c]  <= rem_sh[c];
               root_ff[c] <= {root_ff[c][9:0], 1'b0};
            end
         end
         step_ff <= step_ff + 4'd1;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (load_out) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tdata <= {mag[2], mag[1], mag[0]};
         rsp_tlast <= item_ff.last;
      end
   end

`ifndef NO_ASSERTIONS
   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (root_ff[0] < 11'd1443 && root_ff[1] < 11'd1443 &&
                               root_ff[2] < 11'd1443))
      else $error("root larger than any gradient allows");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (rem_ff[0] <= {root_ff[0], 1'b0} &&
                               rem_ff[1] <= {root_ff[1], 1'b0} &&
                               rem_ff[2] <= {root_ff[2], 1'b0}))
      else $error("root remainder out of range");
   a_out_from_root: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_OUT)
      else $error("result beat raised outside output state");
`endif

endmodule

`default_nettype wire

/* hw/rtl/sobel_edge_magnitude_rgb_core.sv */
// A pixel beat passes the queue and the back end's idle and update states; a beat
// that completes a result also passes the gradient, square, root and output states.
// The back end takes no new beat from the queue until it is done with the last one.
// Results lag their centre pixel by one row plus one pixel of the stream.
// Reset (synchronous, active high) clears positions, window, queue and output
// valid, and sets the image size to 640 x 480; row stores are not cleared.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_core
// Streaming 3x3 Sobel edge magnitude per RGB channel, saturated to 8 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude_rgb_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // pixel_red, pixel_green, pixel_blue
   input  wire logic        req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // edge_red, edge_green, edge_blue
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_wdata
);
   import sem_pkg::*;

   queue_status_type status;
   item_type         push_item, pop_item;
   logic             push, pop;

   sem_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .push       (push),
      .push_item  (push_item)
   );

   sem_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (status)
   );

   sem_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
